// ===== rtl/dctr_pkg.sv =====
package dctr_pkg;

  localparam int MAX_CHUNK_DEF = 64;
  localparam int OFFSET_BITS_DEF = 48;
  localparam int TOP_DIGITS = 18;
  localparam int POS_W = 61;
  localparam int DIG_W = 5;
  localparam int CNT_W = 7;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAND,
    ST_DIV,
    ST_DIGITS,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic band_step;
    logic div_init;
    logic div_step;
    logic dig_init;
    logic dig_step;
    logic emit;
  } dctr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic band_done;
    logic div_done;
    logic dig_done;
    logic emit_last;
  } dctr_sts_t;

  // Power of ten for index 0..18, as a constant table
  function automatic logic [POS_W-1:0] pow_ten(input logic [DIG_W-1:0] k);
    logic [POS_W-1:0] p;
    case (k)
      5'd0:    p = 61'd1;
      5'd1:    p = 61'd10;
      5'd2:    p = 61'd100;
      5'd3:    p = 61'd1000;
      5'd4:    p = 61'd10000;
      5'd5:    p = 61'd100000;
      5'd6:    p = 61'd1000000;
      5'd7:    p = 61'd10000000;
      5'd8:    p = 61'd100000000;
      5'd9:    p = 61'd1000000000;
      5'd10:   p = 61'd10000000000;
      5'd11:   p = 61'd100000000000;
      5'd12:   p = 61'd1000000000000;
      5'd13:   p = 61'd10000000000000;
      5'd14:   p = 61'd100000000000000;
      5'd15:   p = 61'd1000000000000000;
      5'd16:   p = 61'd10000000000000000;
      5'd17:   p = 61'd100000000000000000;
      5'd18:   p = 61'd1000000000000000000;
      default: p = 61'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/dctr_ctrl.sv =====
module dctr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dctr_pkg::dctr_sts_t sts,
  output dctr_pkg::dctr_cmd_t cmd,
  output logic               busy
);

  dctr_pkg::state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dctr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dctr_pkg::ST_IDLE:   if (start) state_next = dctr_pkg::ST_BAND;
      dctr_pkg::ST_BAND: begin
        if (sts.count_zero) state_next = dctr_pkg::ST_IDLE;
        else if (sts.band_done) state_next = dctr_pkg::ST_DIV;
      end
      dctr_pkg::ST_DIV:    if (sts.div_done) state_next = dctr_pkg::ST_DIGITS;
      dctr_pkg::ST_DIGITS: if (sts.dig_done) state_next = dctr_pkg::ST_EMIT;
      dctr_pkg::ST_EMIT:   if (sts.emit_last) state_next = dctr_pkg::ST_IDLE;
      default:             state_next = dctr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      dctr_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      dctr_pkg::ST_BAND: begin
        cmd.band_step = !sts.band_done;
        cmd.div_init = sts.band_done;
      end
      dctr_pkg::ST_DIV: begin
        cmd.div_step = !sts.div_done;
        cmd.dig_init = sts.div_done;
      end
      dctr_pkg::ST_DIGITS: cmd.dig_step = !sts.dig_done;
      dctr_pkg::ST_EMIT:   cmd.emit = 1'b1;
      default:             cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (state == dctr_pkg::ST_IDLE) |-> !busy) else $error("idle but busy");
  a_zero_exits: assert property (@(posedge clk) disable iff (rst)
    (state == dctr_pkg::ST_BAND && sts.count_zero) |=> state == dctr_pkg::ST_IDLE)
    else $error("zero count did not finish");
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == dctr_pkg::ST_EMIT) else $error("emit outside emit state");
`endif

endmodule

// ===== rtl/dctr_dp.sv =====
module dctr_dp #(
  parameter int MAX_CHUNK = dctr_pkg::MAX_CHUNK_DEF,
  parameter int OFFSET_BITS = dctr_pkg::OFFSET_BITS_DEF
) (
  input  logic                       clk,
  input  logic [47:0]                start_offset,
  input  logic [6:0]                 byte_count,
  input  dctr_pkg::dctr_cmd_t        cmd,
  output dctr_pkg::dctr_sts_t        sts,
  output logic                       strobe,
  output logic [7:0]                 char_code,
  output logic                       last_char
);

  localparam int PW = dctr_pkg::POS_W;
  localparam int DW = dctr_pkg::DIG_W;
  localparam int CW = dctr_pkg::CNT_W;
  localparam int OB = (OFFSET_BITS < 48) ? OFFSET_BITS : 48;

  logic [PW-1:0] rest;
  logic [PW-1:0] band;
  logic [DW-1:0] digits;
  logic          at_zero;
  logic [CW-1:0] remain;
  logic [PW-1:0] quot;
  logic [PW-1:0] acc;
  logic [6:0]    div_cnt;
  logic [DW-1:0] place;
  logic [3:0]    dig [dctr_pkg::TOP_DIGITS];
  logic [3:0]    dig_adj [dctr_pkg::TOP_DIGITS];
  logic [PW-1:0] num;
  logic [6:0]    dig_cnt;
  logic [CW-1:0] cnt_sat;
  logic [PW-1:0] divisor;
  logic [PW-1:0] acc_sh;
  logic [PW-1:0] band_next;
  logic [3:0]    cur_dig;

  assign cnt_sat = (byte_count > CW'(MAX_CHUNK)) ? CW'(MAX_CHUNK) : byte_count;
  assign divisor = PW'(digits) + PW'(1);
  // Next band size: band * 10 * (d+2)/(d+1), computed from pow_ten
  assign band_next = PW'(PW'(9) * dctr_pkg::pow_ten(digits)) * PW'(digits + DW'(2));
  assign acc_sh = {acc[PW-2:0], quot[PW-1]};

  assign sts.count_zero = (remain == '0);
  assign sts.band_done  = (rest < band) || (digits >= DW'(dctr_pkg::TOP_DIGITS)) || at_zero;
  assign sts.div_done   = (div_cnt == 7'(PW));
  assign sts.dig_done   = (dig_cnt == 7'(PW));
  assign sts.emit_last  = (remain == CW'(1));

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < dctr_pkg::TOP_DIGITS; i++) begin
      dig_adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
  end

  // Carry into position i when all lower digits are nine
  function automatic logic carry_in(input int i);
    logic c;
    c = 1'b1;
    for (int j = 0; j < dctr_pkg::TOP_DIGITS; j++) begin
      if (j < i && dig[j] != 4'd9) c = 1'b0;
    end
    return c;
  endfunction

  // Seek, divide, split digits and walk the text
  always_ff @(posedge clk) begin
    strobe <= cmd.emit;
    if (cmd.load) begin
      rest    <= PW'(start_offset[OB-1:0]) - PW'(1);
      at_zero <= (start_offset[OB-1:0] == '0);
      band    <= PW'(18);
      digits  <= DW'(1);
      remain  <= cnt_sat;
    end
    // Step one band
    if (cmd.band_step) begin
      rest   <= rest - band;
      digits <= digits + DW'(1);
      band   <= band_next;
    end
    // Restoring divide by digits+1, one bit per cycle
    if (cmd.div_init) begin
      quot    <= rest;
      acc     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + 7'(1);
      if (acc_sh >= divisor) begin
        acc  <= acc_sh - divisor;
        quot <= {quot[PW-2:0], 1'b1};
      end else begin
        acc  <= acc_sh;
        quot <= {quot[PW-2:0], 1'b0};
      end
    end
    // Convert number to BCD by shift and add three, one bit per cycle
    if (cmd.dig_init) begin
      num     <= dctr_pkg::pow_ten(digits - DW'(1)) + quot;
      place   <= acc[DW-1:0];
      dig_cnt <= '0;
      for (int i = 0; i < dctr_pkg::TOP_DIGITS; i++) begin
        dig[i] <= 4'd0;
      end
    end
    if (cmd.dig_step) begin
      dig[0] <= {dig_adj[0][2:0], num[PW-1]};
      for (int i = 1; i < dctr_pkg::TOP_DIGITS; i++) begin
        dig[i] <= {dig_adj[i][2:0], dig_adj[i-1][3]};
      end
      num     <= {num[PW-2:0], 1'b0};
      dig_cnt <= dig_cnt + 7'(1);
    end
    // Emit one character, then advance position
    if (cmd.emit) begin
      last_char <= (remain == CW'(1));
      remain    <= remain - CW'(1);
      if (at_zero) begin
        char_code <= dctr_pkg::CHAR_ZERO;
        at_zero   <= 1'b0;
        place     <= '0;
        digits    <= DW'(1);
        // Number 1 follows
        dig[0]    <= 4'd1;
      end else begin
        char_code <= (place == '0) ? dctr_pkg::CHAR_SPACE
                     : (dctr_pkg::CHAR_ZERO | {4'h0, cur_dig});
        if (place == digits) begin
          place <= '0;
          // Increment stored number, growing a digit on carry out
          for (int i = 0; i < dctr_pkg::TOP_DIGITS; i++) begin
            if (DW'(i) < digits) begin
              if (dig[i] == 4'd9 && (i == 0 || carry_in(i))) dig[i] <= 4'd0;
              else if (i == 0 || carry_in(i)) dig[i] <= dig[i] + 4'd1;
            end else if (DW'(i) == digits && carry_in(i)) begin
              dig[i] <= 4'd1;
            end
          end
          if (carry_in(int'(digits))) digits <= digits + DW'(1);
        end else begin
          place <= place + DW'(1);
        end
      end
    end
  end

  assign cur_dig = dig[DW'(digits - place)];

`ifndef SYNTHESIS
  a_emit_strobe: assert property (@(posedge clk) cmd.emit |=> strobe)
    else $error("emit without strobe");
  a_last_once: assert property (@(posedge clk)
    (strobe && last_char) |-> !$past(strobe && last_char, 1) || !$past(cmd.emit, 2))
    else $error("double last");
  a_place_range: assert property (@(posedge clk) cmd.emit && !at_zero |-> place <= digits)
    else $error("place beyond digits");
`endif

endmodule

// ===== rtl/decimal_count_text_range_core.sv =====
// After a request transfers, the datapath seeks the digit band, divides by the digit count,
// converts the quotient to BCD and then emits the text; the seek skips 0 to 17 digit bands.
// Throughput: one character per cycle while emitting; a new request transfers only when busy
// is low again, after the last character (a zero count ends the request in the seek state).
// Reset (synchronous, active high) returns the controller to idle; the receiver cannot stall.
module decimal_count_text_range_core #(
  parameter int MAX_CHUNK = dctr_pkg::MAX_CHUNK_DEF,
  parameter int OFFSET_BITS = dctr_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] start_offset,
  input  logic [6:0]  byte_count,
  output logic        strobe,
  output logic [7:0]  char_code,
  output logic        last_char
);

  dctr_pkg::dctr_cmd_t cmd;
  dctr_pkg::dctr_sts_t sts;
  logic                dp_strobe;

  dctr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  dctr_dp #(.MAX_CHUNK(MAX_CHUNK), .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk(clk), .start_offset(start_offset), .byte_count(byte_count),
    .cmd(cmd), .sts(sts), .strobe(dp_strobe), .char_code(char_code),
    .last_char(last_char)
  );

  // Drop the strobe while in reset
  assign strobe = dp_strobe && !rst;

endmodule
